// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the allocator RTL
// Clocked property checks that report through $error.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk, skipped while rst is high
`define AM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising edge of clk, also during reset
`define AM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/fpba_pkg.sv =====
// ---------------------------------------------------------------------------
// fpba_pkg
// Types and codes shared by the fit-policy block allocator modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpba_pkg;

  // Field widths of the beats on the two channels
  localparam int SIZE_W      = 16;
  localparam int SLOT_W      = 4;
  localparam int CHOSEN_W    = 4;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int POLICY_W    = 2;
  localparam int COUNT_W     = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  // Policy codes; the unused code behaves as first fit
  localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

  // Input action codes
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] load_slot;
    logic [SIZE_W-1:0] size;
  } alloc_in_t;

  typedef struct packed {
    logic                granted;
    logic [CHOSEN_W-1:0] chosen_block;
    logic [SIZE_W-1:0]   remaining_size;
  } alloc_out_t;

  // Control from the sequencer into the shared compare unit
  typedef struct packed {
    logic                found;
    logic [POLICY_W-1:0] policy;
  } fit_ctl_t;

  // Decisions from the shared compare unit
  typedef struct packed {
    logic fits;
    logic take;
  } fit_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/fit_policy_block_allocator.sv =====
// ---------------------------------------------------------------------------
// fit_policy_block_allocator
// Table of block free sizes with first, best and worst fit allocation.
// ---------------------------------------------------------------------------
// Load beat: written into the table in the cycle it is taken, no result.
// Request beat: a sequencer streams one table entry per cycle through a shared
// compare unit; once the output register is free it writes the pick's remainder
// back and registers the result. Input is stalled for the whole request; the
// output register lets the next beat in while a result waits.
// Reset (rst, synchronous) zeroes the table through per-entry valid bits, at once.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fit_policy_block_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fpba_pkg::alloc_in_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fpba_pkg::alloc_out_t                out_data,
  input  logic                                cfg_we,
  input  logic [fpba_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import fpba_pkg::*;

  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int WIDE_W = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;

  state_t               state;
  state_t               state_next;

  logic [POLICY_W-1:0]  fit_policy;
  logic [COUNT_W-1:0]   block_count;

  logic [POLICY_W-1:0]  policy;
  logic [CNT_W-1:0]     count_lim;
  logic [CNT_W-1:0]     rd_idx;
  logic                 dv;
  logic [IDX_W-1:0]     dv_idx;
  logic                 found;
  logic [IDX_W-1:0]     pick;
  logic [SIZE_BITS-1:0] best_size;
  logic [SIZE_BITS-1:0] req_size;

  logic                 in_accept;
  logic                 out_accept;
  logic                 can_post;
  logic                 tbl_we;
  logic [IDX_W-1:0]     tbl_waddr;
  logic [SIZE_BITS-1:0] tbl_wdata;
  logic [SIZE_BITS-1:0] rd_data;

  logic [WIDE_W-1:0]    in_size_wide;
  logic [SIZE_BITS-1:0] in_size;
  logic [31:0]          slot_wide;
  logic                 slot_in_range;
  logic [CNT_W-1:0]     count_clip;

  logic [SIZE_BITS-1:0] fit_entry;
  fit_ctl_t             fit_ctl;
  fit_res_t             fit_res;
  logic [SIZE_BITS-1:0] fit_remain;
  logic [WIDE_W-1:0]    remain_wide;
  logic [31:0]          pick_wide;
  logic                 out_zero;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign can_post   = !out_valid || out_accept;

  // Fit the beat's fields to the table width
  assign in_size_wide  = WIDE_W'(in_data.size);
  assign in_size       = in_size_wide[SIZE_BITS-1:0];
  assign slot_wide     = 32'(in_data.load_slot);
  assign slot_in_range = (slot_wide < 32'(MAX_BLOCKS));
  assign count_clip    = (32'(block_count) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                              : CNT_W'(block_count);

  // Table of free sizes
  fpba_table #(
    .DEPTH  (MAX_BLOCKS),
    .DATA_W (SIZE_BITS),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // Shared compare and subtract unit: scans entries, then forms the remainder
  assign fit_entry     = (state == ST_DONE) ? best_size : rd_data;
  assign fit_ctl.found  = found;
  assign fit_ctl.policy = policy;

  fpba_fit_unit #(
    .DATA_W (SIZE_BITS)
  ) u_fit (
    .entry  (fit_entry),
    .req    (req_size),
    .best   (best_size),
    .ctl    (fit_ctl),
    .res    (fit_res),
    .remain (fit_remain)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && (in_data.action == ACT_REQUEST)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((rd_idx == count_lim) && !dv) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_post) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs: input stall and table write port
  always_comb begin
    in_stall  = 1'b1;
    tbl_we    = 1'b0;
    tbl_waddr = pick;
    tbl_wdata = fit_remain;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        tbl_we    = in_valid && (in_data.action == ACT_LOAD) && slot_in_range;
        tbl_waddr = slot_wide[IDX_W-1:0];
        tbl_wdata = in_size;
      end
      ST_SCAN: begin
        in_stall = 1'b1;
      end
      ST_DONE: begin
        tbl_we = can_post && found;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fit_policy  <= FIT_FIRST;
      block_count <= '0;
      rd_idx      <= '0;
      dv          <= 1'b0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      // Take configuration writes
      if (cfg_we) begin
        case (cfg_idx)
          REG_FIT_POLICY:  fit_policy  <= cfg_data[POLICY_W-1:0];
          REG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_accept && (in_data.action == ACT_REQUEST)) begin
            rd_idx <= '0;
            dv     <= 1'b0;
            found  <= 1'b0;
          end
        end
        ST_SCAN: begin
          // Advance the read address until the counted blocks are issued
          if (rd_idx != count_lim) begin
            rd_idx <= rd_idx + CNT_W'(1);
            dv     <= 1'b1;
          end else begin
            dv <= 1'b0;
          end
          if (dv && fit_res.take) begin
            found <= 1'b1;
          end
        end
        default: ;
      endcase

      // Hold the result until it is taken
      if (state == ST_DONE && can_post) begin
        out_valid <= 1'b1;
      end else if (out_accept) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  assign remain_wide = WIDE_W'(fit_remain);
  assign pick_wide   = 32'(pick);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept && (in_data.action == ACT_REQUEST)) begin
      req_size  <= in_size;
      policy    <= fit_policy;
      count_lim <= count_clip;
    end
    if (state == ST_SCAN) begin
      dv_idx <= rd_idx[IDX_W-1:0];
      if (dv && fit_res.take) begin
        pick      <= dv_idx;
        best_size <= rd_data;
      end
    end
    if (state == ST_DONE && can_post) begin
      out_data.granted        <= found;
      out_data.chosen_block   <= found ? pick_wide[CHOSEN_W-1:0] : '0;
      out_data.remaining_size <= found ? remain_wide[SIZE_W-1:0] : '0;
    end
  end

  // Denied beats carry zero fields
  assign out_zero = (out_data.chosen_block == '0) && (out_data.remaining_size == '0);

  // Checks
  `AM_ASSERT(a_pick_fits, (state == ST_SCAN && found) |-> (best_size >= req_size), "pick below request")
  `AM_ASSERT(a_idx_bound, (state == ST_SCAN) |-> (rd_idx <= count_lim), "scan index past count")
  `AM_ASSERT(a_dv_in_scan, dv |-> (state == ST_SCAN), "read data flagged outside scan")
  `AM_ASSERT(a_deny_zero, (out_valid && !out_data.granted) |-> out_zero, "denied result not zero")

endmodule

// ===== rtl/fpba_table.sv =====
// ---------------------------------------------------------------------------
// fpba_table
// Free-size table: one write port, one registered read port, and a valid
// bit per entry so that an entry never written since reset reads as zero.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpba_table #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [DATA_W-1:0] rd_mem;
  logic              rd_vld;

  // Write and read the storage array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_mem <= mem[raddr];
  end

  // Track entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_vld <= valid[raddr];
    end
  end

  // Unwritten entries read as zero
  assign rdata = rd_vld ? rd_mem : '0;

endmodule

// ===== rtl/fpba_fit_unit.sv =====
// ---------------------------------------------------------------------------
// fpba_fit_unit
// Shared compare and subtract unit: decides whether an entry fits the
// request and beats the current pick, and forms entry minus request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpba_fit_unit #(
  parameter int DATA_W = 16
) (
  input  logic [DATA_W-1:0]   entry,
  input  logic [DATA_W-1:0]   req,
  input  logic [DATA_W-1:0]   best,
  input  fpba_pkg::fit_ctl_t  ctl,
  output fpba_pkg::fit_res_t  res,
  output logic [DATA_W-1:0]   remain
);

  import fpba_pkg::*;

  logic fits;
  logic better;

  // Compare against the request and the current pick
  always_comb begin
    fits = (entry >= req);
    case (ctl.policy)
      FIT_BEST:  better = (entry < best);
      FIT_WORST: better = (entry > best);
      default:   better = 1'b0;
    endcase
    res.fits = fits;
    res.take = fits && (!ctl.found || better);
  end

  // Subtract the request, wrapping at the table width
  assign remain = entry - req;

endmodule
